### rtl/core/csn_pkg.sv
// Shared types, widths, codes and defaults for the capsule sum and normalize core.
package csn_pkg;

   // Parameter defaults.
   localparam int NUM_CLASSES_DEF = 10;
   localparam int CAPS_DIM_DEF    = 16;
   localparam int FRAC_BITS_DEF   = 4;

   // Fixed field and datapath widths.
   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 8;
   localparam int SAMPLE_W = 16;
   localparam int RESULT_W = 8;
   localparam int ACC_W    = 32;
   localparam int COEF_W   = 7;
   localparam int MAG_W    = 16;
   localparam int PROD_W   = COEF_W + MAG_W;
   localparam int NORM_W   = 15;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Item function codes.
   localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Register indexes, decoded from address bit 2.
   localparam logic REG_COEF_SUM = 1'b0;
   localparam logic REG_COEF_MAX = 1'b1;

   localparam logic [COEF_W-1:0] COEF_RESET = 7'd7;

   // Status of the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### rtl/core/csn_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module csn_div
   import csn_pkg::*;
#(
   parameter int DVD_W = 20,
   parameter int DVS_W = NORM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_status_type   status,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             take;

   // The partial remainder stays below the divisor, so the trial fits in one more bit.
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### rtl/core/capsule_sum_and_norm_normalize_core.sv
// Top level of the capsule sum and normalize core: accumulator memory, scan and control.
//
// Usage. Items arrive on the req_ channel (valid/ready). An accumulate item adds the
// signed sample to one saturating 32-bit accumulator in a memory with one read and one
// write port; a read item returns one normalized 8-bit result on the rsp_ channel; a clear
// item zeroes all accumulators. Accumulate and clear items never produce a transfer on rsp_.
// Throughput: accumulate items are taken one per cycle while the sequencer is idle. The
// memory is read at the transfer and written back in the following cycle; a back-to-back
// update of the same slot takes the just-written sum from a forwarding register instead
// of the stale read. A read item walks the NUM_CLASSES accumulators of its dimension
// through the one read port, one per cycle, then forms the norm, runs the divider unless
// the norm is zero, and loads the output register.
// A read with a class out of range skips the scan and answers with zero.
// A clear item sweeps the memory one entry per cycle, all NUM_CLASSES * CAPS_DIM entries.
// Reset runs the same sweep; req_ready stays low until it ends. The coefficient
// registers return to 7 at once.
// Stalls: the result sits in an output register while rsp_ready is low; accumulate
// and clear items are still taken meanwhile, and a following read stops only at the
// point where its own result would overwrite the waiting one. The user must make
// csr_ port configuration writes only while the core is idle; the core does not enforce it.
module capsule_sum_and_norm_normalize_core
   import csn_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int CAPS_DIM    = CAPS_DIM_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // Input items.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [FUNC_W-1:0]          req_func,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   // Results.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RESULT_W-1:0] rsp_result,
   output logic                       rsp_zero_divisor,
   // Configuration registers.
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int DEPTH = NUM_CLASSES * CAPS_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(NUM_CLASSES);
   localparam int DVD_W = SAMPLE_W + FRAC_BITS;

   // Slot split by reciprocal multiplication; the error stays below one part in
   // CAPS_DIM for every 8-bit slot, so the class comes out exact.
   localparam int DIV_SH    = 16;
   localparam int CLS_RECIP = (1 << DIV_SH) / CAPS_DIM + 1;
   localparam int CLS_PW    = SLOT_W + DIV_SH + 1;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_MAXP  = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   // Accumulator memory.
   logic [ACC_W-1:0] acc_mem [DEPTH];
   logic [ACC_W-1:0] rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [ACC_W-1:0] wr_data;

   // Control state.
   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [AW-1:0]       scan_addr_ff, scan_addr_in;
   logic [CW-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0]       tgt_ff, tgt_in;
   logic [COEF_W-1:0]   coef_sum_ff, coef_sum_in;
   logic [COEF_W-1:0]   coef_max_ff, coef_max_in;

   // Accumulate write-back stage and forwarding.
   logic                       pend_vld_ff;
   logic [AW-1:0]              pend_addr_ff;
   logic signed [SAMPLE_W-1:0] pend_sample_ff;
   logic                       fwd_hit_ff;
   logic [ACC_W-1:0]           fwd_data_ff;
   logic [ACC_W-1:0]           old_acc;
   logic [ACC_W:0]             acc_ext;
   logic [ACC_W-1:0]           acc_sum;

   // Scan pipeline.
   logic                       rd_vld_ff, rd_tgt_ff, rd_last_ff;
   logic                       p1_vld_ff, p1_last_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic signed [SAMPLE_W-1:0] sc_ff;
   logic [NORM_W-1:0]          l1_ff, l1_in;
   logic [MAG_W-1:0]           mx_ff, mx_in;
   logic [PROD_W-1:0]          prod2_ff;
   logic signed [ACC_W-1:0]    shifted;
   logic signed [SAMPLE_W-1:0] squash;
   logic [MAG_W-1:0]           squash_mag;
   logic [PROD_W-1:0]          term_w;
   logic [NORM_W-1:0]          term;
   logic [NORM_W:0]            l1_sum;

   // Norm, divide and result.
   logic [PROD_W-1:0]     max_w;
   logic [NORM_W-1:0]     max_term;
   logic [NORM_W:0]       l2_sum;
   logic [NORM_W-1:0]     l2;
   logic [MAG_W-1:0]      sc_mag;
   logic                  div_start;
   div_status_type        div_st;
   logic [DVD_W-1:0]      div_quo;
   logic [RESULT_W-1:0]   res_val_ff, res_val_in;
   logic                  res_zero_ff, res_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_result_ff;
   logic                  rsp_zero_ff;
   logic                  rsp_load;

   // Item decode.
   logic                  req_xfer;
   logic                  acc_xfer;
   logic [CLS_PW-1:0]     cls_prod;
   logic [SLOT_W-1:0]     req_cls;
   logic [SLOT_W-1:0]     req_dim;
   logic                  csr_wr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign cls_prod  = CLS_PW'(req_slot) * CLS_PW'(CLS_RECIP);
   assign req_cls   = cls_prod[DIV_SH +: SLOT_W];
   assign req_dim   = req_slot - SLOT_W'(req_cls * SLOT_W'(CAPS_DIM));
   // Slots past the last accumulator are dropped on accumulate.
   assign acc_xfer  = req_xfer && (req_func == FUNC_ACC) && (int'(req_slot) < DEPTH);

   // ---------------------------------------------------------------------------------
   // Memory: one registered read port and one write port.
   // ---------------------------------------------------------------------------------
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : AW'(req_slot);

   // The sweep and the write-back never coincide: write-back follows an accumulate
   // transfer, which leaves the sequencer idle.
   assign wr_en   = pend_vld_ff || (state_ff == ST_CLEAR);
   assign wr_addr = pend_vld_ff ? pend_addr_ff : clr_addr_ff;
   assign wr_data = pend_vld_ff ? acc_sum : '0;

   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem[rd_addr];
      if (wr_en) begin
         acc_mem[wr_addr] <= wr_data;
      end
   end

   // Saturating accumulate. A read issued at the edge that wrote the same slot saw the
   // old word, so the forwarded sum replaces it.
   assign old_acc = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign acc_ext = {old_acc[ACC_W-1], old_acc} +
                    {{(ACC_W + 1 - SAMPLE_W){pend_sample_ff[SAMPLE_W-1]}}, pend_sample_ff};
   always_comb begin
      if (acc_ext[ACC_W] != acc_ext[ACC_W-1]) begin
         acc_sum = acc_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sum = acc_ext[ACC_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // Scan datapath: squash, magnitude and weighted term, then running sum and maximum.
   // ---------------------------------------------------------------------------------
   assign shifted = $signed(rd_data_ff) >>> FRAC_BITS;
   always_comb begin
      if (shifted > 32'sd32767) begin
         squash = 16'sh7FFF;
      end else if (shifted < -32'sd32768) begin
         squash = 16'sh8000;
      end else begin
         squash = shifted[SAMPLE_W-1:0];
      end
   end
   // The magnitude of the most negative value is 32768, which still fits unsigned.
   assign squash_mag = squash[SAMPLE_W-1] ? (~squash + MAG_W'(1)) : squash;

   assign term_w = prod_ff >> FRAC_BITS;
   assign term   = (term_w > PROD_W'(32767)) ? {NORM_W{1'b1}} : term_w[NORM_W-1:0];
   assign l1_sum = {1'b0, l1_ff} + {1'b0, term};

   // Norm: weighted maximum plus the weighted sum, both limited to 15 bits.
   assign max_w    = prod2_ff >> FRAC_BITS;
   assign max_term = (max_w > PROD_W'(32767)) ? {NORM_W{1'b1}} : max_w[NORM_W-1:0];
   assign l2_sum   = {1'b0, l1_ff} + {1'b0, max_term};
   assign l2       = l2_sum[NORM_W] ? {NORM_W{1'b1}} : l2_sum[NORM_W-1:0];

   assign sc_mag = sc_ff[SAMPLE_W-1] ? (~sc_ff + MAG_W'(1)) : sc_ff;

   csn_div #(
      .DVD_W (DVD_W),
      .DVS_W (NORM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DVD_W'(sc_mag) << FRAC_BITS),
      .divisor  (l2),
      .status   (div_st),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------------
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      scan_addr_in = scan_addr_ff;
      scan_cnt_in  = scan_cnt_ff;
      tgt_in       = tgt_ff;
      l1_in        = l1_ff;
      mx_in        = mx_ff;
      res_val_in   = res_val_ff;
      res_zero_in  = res_zero_ff;
      div_start    = 1'b0;

      if (p1_vld_ff) begin
         l1_in = l1_sum[NORM_W] ? {NORM_W{1'b1}} : l1_sum[NORM_W-1:0];
         mx_in = (mag_ff > mx_ff) ? mag_ff : mx_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in    = ST_IDLE;
               clr_addr_in = '0;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_func)
                  FUNC_CLEAR: begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                  end
                  FUNC_READ: begin
                     if (int'(req_cls) < NUM_CLASSES) begin
                        state_in     = ST_SCAN;
                        scan_addr_in = AW'(req_dim);
                        scan_cnt_in  = '0;
                        tgt_in       = CW'(req_cls);
                        l1_in        = '0;
                        mx_in        = '0;
                     end else begin
                        // Class out of range: plain zero, no flag.
                        state_in    = ST_DONE;
                        res_val_in  = '0;
                        res_zero_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_addr_in = scan_addr_ff + AW'(CAPS_DIM);
            scan_cnt_in  = scan_cnt_ff + CW'(1);
            if (scan_cnt_ff == CW'(NUM_CLASSES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (p1_vld_ff && p1_last_ff) begin
               state_in = ST_MAXP;
            end
         end
         ST_MAXP: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (l2 == '0) begin
               state_in    = ST_DONE;
               res_val_in  = '0;
               res_zero_in = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_st.done) begin
               state_in    = ST_DONE;
               res_zero_in = 1'b0;
               if (sc_ff[SAMPLE_W-1]) begin
                  res_val_in = (div_quo > DVD_W'(128)) ? 8'h80 : (~div_quo[7:0] + 8'd1);
               end else begin
                  res_val_in = (div_quo > DVD_W'(127)) ? 8'h7F : div_quo[7:0];
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Configuration registers.
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_COEF_MAX) ? CSR_DW'(coef_max_ff)
                                                     : CSR_DW'(coef_sum_ff);
   always_comb begin
      coef_sum_in = coef_sum_ff;
      coef_max_in = coef_max_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_COEF_SUM) begin
            coef_sum_in = csr_pwdata[COEF_W-1:0];
         end else begin
            coef_max_in = csr_pwdata[COEF_W-1:0];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         scan_cnt_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         coef_sum_ff  <= COEF_RESET;
         coef_max_ff  <= COEF_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         scan_cnt_ff  <= scan_cnt_in;
         pend_vld_ff  <= acc_xfer;
         fwd_hit_ff   <= acc_xfer && pend_vld_ff && (AW'(req_slot) == pend_addr_ff);
         rd_vld_ff    <= (state_ff == ST_SCAN);
         p1_vld_ff    <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         coef_sum_ff  <= coef_sum_in;
         coef_max_ff  <= coef_max_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_addr_ff   <= scan_addr_in;
      tgt_ff         <= tgt_in;
      l1_ff          <= l1_in;
      mx_ff          <= mx_in;
      res_val_ff     <= res_val_in;
      res_zero_ff    <= res_zero_in;
      pend_addr_ff   <= AW'(req_slot);
      pend_sample_ff <= req_sample;
      fwd_data_ff    <= acc_sum;
      rd_tgt_ff      <= (scan_cnt_ff == tgt_ff);
      rd_last_ff     <= (scan_cnt_ff == CW'(NUM_CLASSES - 1));
      p1_last_ff     <= rd_last_ff;
      mag_ff         <= squash_mag;
      prod_ff        <= PROD_W'(coef_sum_ff) * PROD_W'(squash_mag);
      prod2_ff       <= PROD_W'(coef_max_ff) * PROD_W'(mx_ff);
      if (rd_vld_ff && rd_tgt_ff) begin
         sc_ff <= squash;
      end
      if (rsp_load) begin
         rsp_result_ff <= res_val_ff;
         rsp_zero_ff   <= res_zero_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_result_ff;
   assign rsp_zero_divisor = rsp_zero_ff;

   // ---------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(pend_vld_ff && (state_ff == ST_CLEAR)))
      else $error("write-back collided with the clearing sweep");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_st.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside the divide step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (int'(scan_cnt_ff) < NUM_CLASSES))
      else $error("scan counter past the last class");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("finished result not presented");

endmodule
